### hw/rtl/vat_pkg.sv
package vat_pkg;

  localparam int CoordWidth  = 32;
  localparam int TrigWidth   = 16;
  localparam int TrigFrac    = 14;
  localparam int CoordFrac   = 16;
  localparam int ProdWidth   = 2 * CoordWidth;
  localparam int ExtWidth    = ProdWidth + 2;
  localparam int CfgIdxWidth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [TrigWidth-1:0]  trig_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [ExtWidth-1:0]   ext_t;

  typedef enum logic [2:0] {
    OpRotX  = 3'd0,
    OpRotY  = 3'd1,
    OpRotZ  = 3'd2,
    OpMoveX = 3'd3,
    OpMoveY = 3'd4,
    OpMoveZ = 3'd5,
    OpScale = 3'd6,
    OpNop   = 3'd7
  } op_e;

  localparam logic [CfgIdxWidth-1:0] CfgCos   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgSin   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBias  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgScale = 2'd3;

  typedef struct packed {
    logic [2:0] opcode;
    coord_t     x_in;
    coord_t     y_in;
    coord_t     z_in;
  } vertex_in_t;

  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
    coord_t z_out;
  } vertex_out_t;

  typedef struct packed {
    trig_t  cos_angle;
    trig_t  sin_angle;
    coord_t shift_bias;
    coord_t scale_factor;
  } cfg_t;

  localparam trig_t  TrigOne  = trig_t'(1) <<< TrigFrac;
  localparam coord_t ScaleOne = coord_t'(1) <<< CoordFrac;

  localparam cfg_t CfgReset = '{
    cos_angle:    TrigOne,
    sin_angle:    '0,
    shift_bias:   '0,
    scale_factor: ScaleOne
  };

  localparam ext_t   ExtOne   = ext_t'(1);
  localparam ext_t   ExtMax   = (ExtOne <<< (CoordWidth - 1)) - ExtOne;
  localparam ext_t   ExtMin   = -(ExtOne <<< (CoordWidth - 1));
  localparam coord_t CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};
  localparam ext_t   RotHalf   = ExtOne <<< (TrigFrac - 1);
  localparam ext_t   ScaleHalf = ExtOne <<< (CoordFrac - 1);

  function automatic ext_t ext_prod(input prod_t p);
    return ext_t'(p);
  endfunction

  function automatic ext_t ext_coord(input coord_t v);
    return ext_t'(v);
  endfunction

  // clamp to the signed coordinate range
  function automatic coord_t sat_coord(input ext_t v);
    coord_t r;
    if (v > ExtMax) begin
      r = CoordMax;
    end else if (v < ExtMin) begin
      r = CoordMin;
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/vat_cfg.sv
module vat_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vat_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [vat_pkg::CoordWidth-1:0]    cfg_wdata_i,
  output vat_pkg::cfg_t                     cfg_o
);

  vat_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        vat_pkg::CfgCos:   cfg_d.cos_angle    = cfg_wdata_i[vat_pkg::TrigWidth-1:0];
        vat_pkg::CfgSin:   cfg_d.sin_angle    = cfg_wdata_i[vat_pkg::TrigWidth-1:0];
        vat_pkg::CfgBias:  cfg_d.shift_bias   = cfg_wdata_i;
        vat_pkg::CfgScale: cfg_d.scale_factor = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vat_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/vertex_axis_transform.sv
// a vertex taken with start passes the input, product and result registers in that order,
// and is then on vertex_o, with result_valid_o high
// throughput: one vertex per cycle, set by the registered multiply stage; busy stays low
// the receiver cannot stall, so every result is shown for exactly one cycle, in order
// reset clears the pipeline valid flags and loads the register reset values
module vertex_axis_transform (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  vat_pkg::vertex_in_t             vertex_i,
  output logic                            result_valid_o,
  output vat_pkg::vertex_out_t            vertex_o,
  input  logic                            cfg_we_i,
  input  logic [vat_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [vat_pkg::CoordWidth-1:0]  cfg_wdata_i
);

  vat_pkg::cfg_t cfg;

  vat_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input register
  logic                s1_valid_q;
  vat_pkg::op_e        s1_op_q;
  vat_pkg::coord_t     s1_x_q, s1_y_q, s1_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= vat_pkg::op_e'(vertex_i.opcode);
      s1_x_q  <= vertex_i.x_in;
      s1_y_q  <= vertex_i.y_in;
      s1_z_q  <= vertex_i.z_in;
    end
  end

  // operand selection for the four multipliers
  vat_pkg::coord_t mul_a [4];
  vat_pkg::coord_t mul_b [4];
  vat_pkg::prod_t  prod  [4];
  vat_pkg::coord_t rot_a, rot_b, cos_ext, sin_ext;
  vat_pkg::op_e    s1_op_eff;

  always_comb begin
    cos_ext = vat_pkg::coord_t'(cfg.cos_angle);
    sin_ext = vat_pkg::coord_t'(cfg.sin_angle);
    case (s1_op_q)
      vat_pkg::OpRotX: begin
        rot_a = s1_y_q;
        rot_b = s1_z_q;
      end
      vat_pkg::OpRotY: begin
        rot_a = s1_x_q;
        rot_b = s1_z_q;
      end
      default: begin
        rot_a = s1_x_q;
        rot_b = s1_y_q;
      end
    endcase
    if (s1_op_q == vat_pkg::OpScale) begin
      mul_a[0] = s1_x_q;
      mul_a[1] = s1_y_q;
      mul_a[2] = s1_z_q;
      mul_a[3] = s1_z_q;
      mul_b[0] = cfg.scale_factor;
      mul_b[1] = cfg.scale_factor;
      mul_b[2] = cfg.scale_factor;
      mul_b[3] = cfg.scale_factor;
    end else begin
      mul_a[0] = rot_a;
      mul_a[1] = rot_b;
      mul_a[2] = rot_a;
      mul_a[3] = rot_b;
      mul_b[0] = cos_ext;
      mul_b[1] = sin_ext;
      mul_b[2] = sin_ext;
      mul_b[3] = cos_ext;
    end
    for (int i = 0; i < 4; i++) begin
      prod[i] = vat_pkg::prod_t'(mul_a[i]) * vat_pkg::prod_t'(mul_b[i]);
    end
    // a zero scale factor leaves the vertex alone
    if (s1_op_q == vat_pkg::OpScale && cfg.scale_factor == '0) begin
      s1_op_eff = vat_pkg::OpNop;
    end else begin
      s1_op_eff = s1_op_q;
    end
  end

  // product register
  logic             s2_valid_q;
  vat_pkg::op_e     s2_op_q;
  vat_pkg::coord_t  s2_x_q, s2_y_q, s2_z_q;
  vat_pkg::prod_t   s2_prod_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_op_q <= s1_op_eff;
      s2_x_q  <= s1_x_q;
      s2_y_q  <= s1_y_q;
      s2_z_q  <= s1_z_q;
      for (int i = 0; i < 4; i++) begin
        s2_prod_q[i] <= prod[i];
      end
    end
  end

  // combine, round half up, saturate
  vat_pkg::ext_t        rot_diff, rot_sum;
  vat_pkg::coord_t      rot_ra, rot_rb, move_x, move_y, move_z;
  vat_pkg::coord_t      scl_x, scl_y, scl_z;
  vat_pkg::vertex_out_t res_d;
  vat_pkg::ext_t        bias_ext;

  always_comb begin
    rot_diff = vat_pkg::ext_prod(s2_prod_q[0]) - vat_pkg::ext_prod(s2_prod_q[1]);
    rot_sum  = vat_pkg::ext_prod(s2_prod_q[2]) + vat_pkg::ext_prod(s2_prod_q[3]);
    rot_ra   = vat_pkg::sat_coord((rot_diff + vat_pkg::RotHalf) >>> vat_pkg::TrigFrac);
    rot_rb   = vat_pkg::sat_coord((rot_sum + vat_pkg::RotHalf) >>> vat_pkg::TrigFrac);
    scl_x = vat_pkg::sat_coord(
        (vat_pkg::ext_prod(s2_prod_q[0]) + vat_pkg::ScaleHalf) >>> vat_pkg::CoordFrac);
    scl_y = vat_pkg::sat_coord(
        (vat_pkg::ext_prod(s2_prod_q[1]) + vat_pkg::ScaleHalf) >>> vat_pkg::CoordFrac);
    scl_z = vat_pkg::sat_coord(
        (vat_pkg::ext_prod(s2_prod_q[2]) + vat_pkg::ScaleHalf) >>> vat_pkg::CoordFrac);
    bias_ext = vat_pkg::ext_coord(cfg.shift_bias);
    move_x = vat_pkg::sat_coord(vat_pkg::ext_coord(s2_x_q) + bias_ext);
    move_y = vat_pkg::sat_coord(vat_pkg::ext_coord(s2_y_q) + bias_ext);
    move_z = vat_pkg::sat_coord(vat_pkg::ext_coord(s2_z_q) + bias_ext);

    res_d.x_out = s2_x_q;
    res_d.y_out = s2_y_q;
    res_d.z_out = s2_z_q;
    case (s2_op_q)
      vat_pkg::OpRotX: begin
        res_d.y_out = rot_ra;
        res_d.z_out = rot_rb;
      end
      vat_pkg::OpRotY: begin
        res_d.x_out = rot_ra;
        res_d.z_out = rot_rb;
      end
      vat_pkg::OpRotZ: begin
        res_d.x_out = rot_ra;
        res_d.y_out = rot_rb;
      end
      vat_pkg::OpMoveX: res_d.x_out = move_x;
      vat_pkg::OpMoveY: res_d.y_out = move_y;
      vat_pkg::OpMoveZ: res_d.z_out = move_z;
      vat_pkg::OpScale: begin
        res_d.x_out = scl_x;
        res_d.y_out = scl_y;
        res_d.z_out = scl_z;
      end
      default: res_d.x_out = s2_x_q;
    endcase
  end

  // result register
  logic                 res_valid_q;
  vat_pkg::vertex_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign vertex_o       = res_q;

  // every result traces back to an earlier input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 3))
    else $error("result without a matching input transaction");

  // no-op vertices come back untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(vertex_i.opcode, 3) == vat_pkg::OpNop
    |-> vertex_o.x_out == $past(vertex_i.x_in, 3)
        && vertex_o.y_out == $past(vertex_i.y_in, 3)
        && vertex_o.z_out == $past(vertex_i.z_in, 3))
    else $error("no-op changed the vertex");

  // a move along x leaves y and z alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(vertex_i.opcode, 3) == vat_pkg::OpMoveX
    |-> vertex_o.y_out == $past(vertex_i.y_in, 3)
        && vertex_o.z_out == $past(vertex_i.z_in, 3))
    else $error("move along x touched another axis");

  // rotation about x keeps x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(vertex_i.opcode, 3) == vat_pkg::OpRotX
    |-> vertex_o.x_out == $past(vertex_i.x_in, 3))
    else $error("rotation about x changed x");

endmodule

### bench/vertex_axis_transform_tb.sv
module vertex_axis_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 1000;

  // wide enough for a full 32x32 product plus rounding without overflow
  typedef logic signed [95:0] acc_t;

  localparam acc_t RotRound   = acc_t'(1) <<< (vat_pkg::TrigFrac - 1);
  localparam acc_t ScaleRound = acc_t'(1) <<< (vat_pkg::CoordFrac - 1);

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            start       = 1'b0;
  logic                            busy;
  vat_pkg::vertex_in_t             vertex_i    = '0;
  logic                            result_valid_o;
  vat_pkg::vertex_out_t            vertex_o;
  logic                            cfg_we_i    = 1'b0;
  logic [vat_pkg::CfgIdxWidth-1:0] cfg_idx_i   = vat_pkg::CfgCos;
  logic [vat_pkg::CoordWidth-1:0]  cfg_wdata_i = '0;

  vat_pkg::cfg_t        shadow_cfg = vat_pkg::CfgReset;
  vat_pkg::vertex_out_t expected_vertices[$];
  bit                   allow_gaps   = 1'b1;
  int                   error_count  = 0;
  int                   sent_count   = 0;
  int                   result_count = 0;
  int                   cfg_sets     = 0;
  int                   idle_cycles  = 0;

  always #5 clk_i = ~clk_i;

  vertex_axis_transform u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .vertex_i       (vertex_i),
    .result_valid_o (result_valid_o),
    .vertex_o       (vertex_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  function automatic vat_pkg::coord_t clamp_coord(acc_t v);
    if (v > acc_t'(vat_pkg::CoordMax)) return vat_pkg::CoordMax;
    if (v < acc_t'(vat_pkg::CoordMin)) return vat_pkg::CoordMin;
    return vat_pkg::coord_t'(v);
  endfunction

  // c*p - s*q or c*p + s*q, rounded half up to Q16.16
  function automatic vat_pkg::coord_t rotate_term(vat_pkg::coord_t p, vat_pkg::coord_t q,
                                                  bit subtract);
    acc_t c, s, pv, qv, sum;
    c  = acc_t'(shadow_cfg.cos_angle);
    s  = acc_t'(shadow_cfg.sin_angle);
    pv = acc_t'(p);
    qv = acc_t'(q);
    sum = subtract ? c * pv - s * qv : c * pv + s * qv;
    return clamp_coord((sum + RotRound) >>> vat_pkg::TrigFrac);
  endfunction

  function automatic vat_pkg::coord_t shift_coord(vat_pkg::coord_t v);
    return clamp_coord(acc_t'(v) + acc_t'(shadow_cfg.shift_bias));
  endfunction

  function automatic vat_pkg::coord_t scale_coord(vat_pkg::coord_t v);
    acc_t prod;
    prod = acc_t'(v) * acc_t'(shadow_cfg.scale_factor);
    return clamp_coord((prod + ScaleRound) >>> vat_pkg::CoordFrac);
  endfunction

  function automatic vat_pkg::vertex_out_t transform_vertex(vat_pkg::vertex_in_t v);
    vat_pkg::vertex_out_t r;
    r.x_out = v.x_in;
    r.y_out = v.y_in;
    r.z_out = v.z_in;
    case (vat_pkg::op_e'(v.opcode))
      vat_pkg::OpRotX: begin
        r.y_out = rotate_term(v.y_in, v.z_in, 1'b1);
        r.z_out = rotate_term(v.z_in, v.y_in, 1'b0);
      end
      vat_pkg::OpRotY: begin
        r.x_out = rotate_term(v.x_in, v.z_in, 1'b1);
        r.z_out = rotate_term(v.z_in, v.x_in, 1'b0);
      end
      vat_pkg::OpRotZ: begin
        r.x_out = rotate_term(v.x_in, v.y_in, 1'b1);
        r.y_out = rotate_term(v.y_in, v.x_in, 1'b0);
      end
      vat_pkg::OpMoveX: r.x_out = shift_coord(v.x_in);
      vat_pkg::OpMoveY: r.y_out = shift_coord(v.y_in);
      vat_pkg::OpMoveZ: r.z_out = shift_coord(v.z_in);
      vat_pkg::OpScale: begin
        // zero factor leaves the vertex as it is
        if (shadow_cfg.scale_factor != '0) begin
          r.x_out = scale_coord(v.x_in);
          r.y_out = scale_coord(v.y_in);
          r.z_out = scale_coord(v.z_in);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic vat_pkg::vertex_in_t make_vertex(vat_pkg::op_e op, vat_pkg::coord_t x,
                                                      vat_pkg::coord_t y, vat_pkg::coord_t z);
    vat_pkg::vertex_in_t v;
    v.opcode = op;
    v.x_in   = x;
    v.y_in   = y;
    v.z_in   = z;
    return v;
  endfunction

  function automatic vat_pkg::coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return vat_pkg::CoordMax;
      1: return vat_pkg::CoordMin;
      2, 3: return vat_pkg::coord_t'(int'($urandom_range(0, 1048576)) - 524288);
      default: return vat_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic vat_pkg::trig_t rand_trig();
    case ($urandom_range(0, 5))
      0: return vat_pkg::TrigOne;
      1: return -vat_pkg::TrigOne;
      2: return '0;
      default: return vat_pkg::trig_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic vat_pkg::coord_t rand_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return vat_pkg::ScaleOne;
      2: return vat_pkg::CoordMax;
      3: return vat_pkg::CoordMin;
      4, 5: return vat_pkg::coord_t'(int'($urandom_range(0, 524288)) - 262144);
      default: return vat_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic vat_pkg::vertex_in_t rand_vertex();
    vat_pkg::vertex_in_t v;
    v.opcode = 3'($urandom_range(0, 7));
    v.x_in   = rand_coord();
    v.y_in   = rand_coord();
    v.z_in   = rand_coord();
    return v;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!allow_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_vertex(vat_pkg::vertex_in_t v);
    int gap;
    start    <= 1'b1;
    vertex_i <= v;
    do @(posedge clk_i); while (busy);
    expected_vertices.push_back(transform_vertex(v));
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start    <= 1'b0;
      vertex_i <= rand_vertex();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vat_pkg::CfgIdxWidth-1:0] idx,
                           logic [vat_pkg::CoordWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      vat_pkg::CfgCos:   shadow_cfg.cos_angle    = data[vat_pkg::TrigWidth-1:0];
      vat_pkg::CfgSin:   shadow_cfg.sin_angle    = data[vat_pkg::TrigWidth-1:0];
      vat_pkg::CfgBias:  shadow_cfg.shift_bias   = data;
      vat_pkg::CfgScale: shadow_cfg.scale_factor = data;
      default: begin
      end
    endcase
  endtask

  // upper bits of the trig writes carry junk, only the low half counts
  task automatic set_config(vat_pkg::trig_t cos_v, vat_pkg::trig_t sin_v,
                            vat_pkg::coord_t bias_v, vat_pkg::coord_t scale_v);
    write_reg(vat_pkg::CfgCos, {16'($urandom), cos_v});
    write_reg(vat_pkg::CfgSin, {16'($urandom), sin_v});
    write_reg(vat_pkg::CfgBias, bias_v);
    write_reg(vat_pkg::CfgScale, scale_v);
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  task automatic compare_field(string field, vat_pkg::coord_t want, vat_pkg::coord_t got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    vat_pkg::vertex_out_t want;
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (expected_vertices.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing pending, expected none actual %h",
                 $time, vertex_o);
      end else begin
        want = expected_vertices.pop_front();
        compare_field("x", want.x_out, vertex_o.x_out);
        compare_field("y", want.y_out, vertex_o.y_out);
        compare_field("z", want.z_out, vertex_o.z_out);
      end
    end
  end

  // counts cycles with no transaction on either side
  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || result_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results pending",
               $time, IdleLimit, expected_vertices.size());
      $display("vertex_axis_transform_tb: errors");
      $finish;
    end
  end

  // identity rotation, zero bias and unit scale straight out of reset
  task automatic test_reset_values();
    for (int op = 0; op < 8; op++)
      send_vertex(make_vertex(vat_pkg::op_e'(op), vat_pkg::CoordMax, vat_pkg::CoordMin,
                              vat_pkg::coord_t'(-1)));
  endtask

  task automatic test_saturation_extremes();
    wait_for_results();
    set_config(vat_pkg::TrigOne, vat_pkg::TrigOne, vat_pkg::CoordMax, vat_pkg::CoordMin);
    send_vertex(make_vertex(vat_pkg::OpRotX, vat_pkg::CoordMax, vat_pkg::CoordMax,
                            vat_pkg::CoordMin));
    send_vertex(make_vertex(vat_pkg::OpRotY, vat_pkg::CoordMax, vat_pkg::CoordMax,
                            vat_pkg::CoordMin));
    send_vertex(make_vertex(vat_pkg::OpRotZ, vat_pkg::CoordMax, vat_pkg::CoordMax,
                            vat_pkg::CoordMin));
    send_vertex(make_vertex(vat_pkg::OpMoveX, vat_pkg::CoordMax, '0, '0));
    send_vertex(make_vertex(vat_pkg::OpMoveY, '0, vat_pkg::CoordMin, '0));
    send_vertex(make_vertex(vat_pkg::OpScale, vat_pkg::CoordMin, vat_pkg::CoordMax,
                            vat_pkg::coord_t'(1)));
    wait_for_results();
    set_config(-vat_pkg::TrigOne, -vat_pkg::TrigOne, vat_pkg::CoordMin, '0);
    send_vertex(make_vertex(vat_pkg::OpRotX, vat_pkg::CoordMin, vat_pkg::CoordMin,
                            vat_pkg::CoordMax));
    send_vertex(make_vertex(vat_pkg::OpRotZ, vat_pkg::CoordMax, vat_pkg::CoordMin, '0));
    send_vertex(make_vertex(vat_pkg::OpMoveZ, '0, '0, vat_pkg::CoordMin));
    send_vertex(make_vertex(vat_pkg::OpScale, vat_pkg::CoordMax, vat_pkg::CoordMin,
                            vat_pkg::coord_t'(12345)));
  endtask

  // half-way products must round up, also for negative values
  task automatic test_rounding();
    wait_for_results();
    set_config(vat_pkg::trig_t'(8192), vat_pkg::trig_t'(-8192), vat_pkg::coord_t'(32768),
               vat_pkg::coord_t'(32768));
    send_vertex(make_vertex(vat_pkg::OpScale, vat_pkg::coord_t'(1), vat_pkg::coord_t'(-1),
                            vat_pkg::coord_t'(3)));
    send_vertex(make_vertex(vat_pkg::OpRotY, vat_pkg::coord_t'(1), '0,
                            vat_pkg::coord_t'(-1)));
    send_vertex(make_vertex(vat_pkg::OpMoveX, vat_pkg::coord_t'(-1), vat_pkg::coord_t'(7),
                            vat_pkg::coord_t'(9)));
  endtask

  task automatic test_pause_until_drained();
    wait_for_results();
    set_config(rand_trig(), rand_trig(), rand_coord(), rand_scale());
    repeat (8) begin
      repeat (10) send_vertex(rand_vertex());
      wait_for_results();
    end
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results();
      case (phase)
        0: set_config(vat_pkg::TrigOne, -vat_pkg::TrigOne, vat_pkg::CoordMax,
                      vat_pkg::CoordMax);
        1: set_config(-vat_pkg::TrigOne, vat_pkg::TrigOne, vat_pkg::CoordMin,
                      vat_pkg::CoordMin);
        2: set_config(vat_pkg::TrigOne, '0, '0, vat_pkg::ScaleOne);
        default: set_config(rand_trig(), rand_trig(), rand_coord(), rand_scale());
      endcase
      // one back-to-back phase with no gaps at all
      allow_gaps = (phase != 3);
      repeat (140) send_vertex(rand_vertex());
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_saturation_extremes();
    test_rounding();
    test_pause_until_drained();
    test_random_stream();
    wait_for_results();
    $display("sent %0d vertices, checked %0d results over %0d register settings",
             sent_count, result_count, cfg_sets);
    $display("covered all opcodes, clamping, rounding, zero scale, gaps and a drain pause");
    if (error_count == 0) begin
      $display("vertex_axis_transform_tb: clean");
    end else begin
      $display("vertex_axis_transform_tb: errors");
    end
    $finish;
  end

endmodule
